// ----- hw/rtl/sst_pkg.sv -----
// Shared constants, codes and types for the session slot table.
package sst_pkg;

    localparam int SLOTS      = 8;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int OP_W       = 3;
    localparam int ROLE_W     = 2;
    localparam int TOKEN_W    = 64;
    localparam int TIME_W     = 32;
    localparam int IDX_W      = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int CMD_W      = 3;

    localparam logic [OP_W-1:0] OP_LOGIN      = OP_W'(0);
    localparam logic [OP_W-1:0] OP_CHECK      = OP_W'(1);
    localparam logic [OP_W-1:0] OP_LOGOUT     = OP_W'(2);
    localparam logic [OP_W-1:0] OP_LOGOUT_ALL = OP_W'(3);
    localparam logic [OP_W-1:0] OP_DROP_USER  = OP_W'(4);

    localparam logic [ROLE_W-1:0] ROLE_NONE  = ROLE_W'(0);
    localparam logic [ROLE_W-1:0] ROLE_USER  = ROLE_W'(1);
    localparam logic [ROLE_W-1:0] ROLE_ADMIN = ROLE_W'(2);

    localparam logic [CFG_IDX_W-1:0] CFG_AUTH     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME = CFG_IDX_W'(1);

    localparam logic [TIME_W-1:0] LIFETIME_RESET = TIME_W'(86400);

    localparam logic [CMD_W-1:0] CMD_NONE       = CMD_W'(0);
    localparam logic [CMD_W-1:0] CMD_WRITE      = CMD_W'(1);
    localparam logic [CMD_W-1:0] CMD_TOUCH      = CMD_W'(2);
    localparam logic [CMD_W-1:0] CMD_CLEAR      = CMD_W'(3);
    localparam logic [CMD_W-1:0] CMD_CLEAR_ALL  = CMD_W'(4);
    localparam logic [CMD_W-1:0] CMD_CLEAR_USER = CMD_W'(5);

    typedef struct packed {
        logic              valid;
        logic              free_found;
        logic [SLOT_W-1:0] free_idx;
        logic              victim_found;
        logic [SLOT_W-1:0] victim_idx;
        logic [TIME_W-1:0] best_age;
        logic              match_found;
        logic [SLOT_W-1:0] match_idx;
        logic              match_admin;
        logic [TIME_W-1:0] match_created;
    } scan_t;

    typedef struct packed {
        logic [TOKEN_W-1:0] token;
        logic [TIME_W-1:0]  now;
        logic               admin;
    } key_t;

    typedef struct packed {
        logic [CMD_W-1:0]  kind;
        logic [SLOT_W-1:0] idx;
    } cmd_t;

endpackage

// ----- hw/rtl/sst_if.sv -----
// Handshake channel interfaces for requests, responses and configuration.
interface sst_req_if import sst_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [ROLE_W-1:0]   granted_role;
    logic [TOKEN_W-1:0]  token;
    logic [TIME_W-1:0]   now_seconds;

    modport source (output valid, operation, granted_role, token, now_seconds,
                    input ready);
    modport sink   (input valid, operation, granted_role, token, now_seconds,
                    output ready);
endinterface

interface sst_rsp_if import sst_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ROLE_W-1:0] result_role;
    logic [IDX_W-1:0]  slot_index;
    logic              slot_valid;
    logic              evicted;
    logic              expired;

    modport source (output valid, result_role, slot_index, slot_valid, evicted, expired,
                    input ready);
    modport sink   (input valid, result_role, slot_index, slot_valid, evicted, expired,
                    output ready);
endinterface

interface sst_cfg_if import sst_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/sst_cell.sv -----
// One table slot: holds a session and folds its view into the passing scan record.
module sst_cell import sst_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SLOT_W-1:0] cell_idx,
    input  key_t              key,
    input  cmd_t              cmd,
    input  scan_t             scan_in,
    output scan_t             scan_out
);

    logic               active_reg, active_next;
    logic [TOKEN_W-1:0] token_reg, token_next;
    logic               admin_reg, admin_next;
    logic [TIME_W-1:0]  created_reg, created_next;
    logic [TIME_W-1:0]  used_reg, used_next;
    scan_t              scan_reg, scan_next;
    logic               mine;
    logic [TIME_W-1:0]  age;

    assign mine = (cmd.idx == cell_idx);
    assign age  = key.now - used_reg;

    always_comb
    begin
        active_next  = active_reg;
        token_next   = token_reg;
        admin_next   = admin_reg;
        created_next = created_reg;
        used_next    = used_reg;
        case (cmd.kind)
            CMD_WRITE:
            begin
                if (mine)
                begin
                    active_next  = 1'b1;
                    token_next   = key.token;
                    admin_next   = key.admin;
                    created_next = key.now;
                    used_next    = key.now;
                end
            end
            CMD_TOUCH:
            begin
                if (mine)
                    used_next = key.now;
            end
            CMD_CLEAR:
            begin
                if (mine)
                    active_next = 1'b0;
            end
            CMD_CLEAR_ALL:
                active_next = 1'b0;
            CMD_CLEAR_USER:
            begin
                if (!admin_reg)
                    active_next = 1'b0;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        scan_next = scan_in;
        if (active_reg)
        begin
            if (!scan_in.free_found && (key.admin || !admin_reg))
            begin
                if (!scan_in.victim_found || age > scan_in.best_age)
                begin
                    scan_next.victim_found = 1'b1;
                    scan_next.victim_idx   = cell_idx;
                    scan_next.best_age     = age;
                end
            end
            if (!scan_in.match_found && key.token != '0 && token_reg == key.token)
            begin
                scan_next.match_found   = 1'b1;
                scan_next.match_idx     = cell_idx;
                scan_next.match_admin   = admin_reg;
                scan_next.match_created = created_reg;
            end
        end
        else if (!scan_in.free_found)
        begin
            scan_next.free_found = 1'b1;
            scan_next.free_idx   = cell_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            scan_reg   <= '0;
        end
        else
        begin
            active_reg <= active_next;
            scan_reg   <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        token_reg   <= token_next;
        admin_reg   <= admin_next;
        created_reg <= created_next;
        used_reg    <= used_next;
    end

    assign scan_out = scan_reg;

endmodule

// ----- hw/rtl/sst_ctrl.sv -----
// Sequencer: takes requests, launches the slot scan, decides and issues updates.
module sst_ctrl import sst_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    sst_req_if.sink         req,
    sst_rsp_if.source       rsp,
    sst_cfg_if.sink         cfg,
    output key_t            key,
    output cmd_t            cmd,
    output scan_t           scan_start,
    input  scan_t           scan_done
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [ROLE_W-1:0] role_reg, role_next;
    key_t              key_reg, key_next;
    logic              launch_reg, launch_next;
    scan_t             found_reg, found_next;
    logic              auth_reg, auth_next;
    logic [TIME_W-1:0] lifetime_reg, lifetime_next;

    logic              out_valid_reg, out_valid_next;
    logic [ROLE_W-1:0] out_role_reg, out_role_next;
    logic [IDX_W-1:0]  out_idx_reg, out_idx_next;
    logic              out_slot_reg, out_slot_next;
    logic              out_ev_reg, out_ev_next;
    logic              out_ex_reg, out_ex_next;

    logic              accept;
    logic              req_role_ok;
    logic              needs_scan;
    logic              fire;
    logic              login_ok;
    logic [TIME_W-1:0] age;
    logic [ROLE_W-1:0] res_role;
    logic [SLOT_W-1:0] res_idx;
    logic              res_slot, res_ev, res_ex;
    cmd_t              res_cmd;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign req_role_ok = (req.granted_role == ROLE_USER) || (req.granted_role == ROLE_ADMIN);
    assign needs_scan  = ((req.operation == OP_LOGIN) && auth_reg && req_role_ok
                          && req.token != '0)
                      || ((req.operation == OP_CHECK) && auth_reg)
                      || (req.operation == OP_LOGOUT);

    assign fire     = (state_reg == ST_FINISH) && (!out_valid_reg || rsp.ready);
    assign login_ok = ((role_reg == ROLE_USER) || (role_reg == ROLE_ADMIN))
                   && key_reg.token != '0;
    assign age      = key_reg.now - found_reg.match_created;

    // decide the answer and the table update for the finished item
    always_comb
    begin
        res_role     = ROLE_NONE;
        res_idx      = '0;
        res_slot     = 1'b0;
        res_ev       = 1'b0;
        res_ex       = 1'b0;
        res_cmd.kind = CMD_NONE;
        res_cmd.idx  = '0;
        case (op_reg)
            OP_LOGIN:
            begin
                if (!auth_reg)
                    res_role = ROLE_ADMIN;
                else if (login_ok && found_reg.free_found)
                begin
                    res_role     = role_reg;
                    res_idx      = found_reg.free_idx;
                    res_slot     = 1'b1;
                    res_cmd.kind = CMD_WRITE;
                    res_cmd.idx  = found_reg.free_idx;
                end
                else if (login_ok && found_reg.victim_found)
                begin
                    res_role     = role_reg;
                    res_idx      = found_reg.victim_idx;
                    res_slot     = 1'b1;
                    res_ev       = 1'b1;
                    res_cmd.kind = CMD_WRITE;
                    res_cmd.idx  = found_reg.victim_idx;
                end
            end
            OP_CHECK:
            begin
                if (!auth_reg)
                    res_role = ROLE_ADMIN;
                else if (found_reg.match_found)
                begin
                    res_idx     = found_reg.match_idx;
                    res_slot    = 1'b1;
                    res_cmd.idx = found_reg.match_idx;
                    if (age > lifetime_reg)
                    begin
                        res_ex       = 1'b1;
                        res_cmd.kind = CMD_CLEAR;
                    end
                    else
                    begin
                        res_role     = found_reg.match_admin ? ROLE_ADMIN : ROLE_USER;
                        res_cmd.kind = CMD_TOUCH;
                    end
                end
            end
            OP_LOGOUT:
            begin
                if (found_reg.match_found)
                begin
                    res_idx      = found_reg.match_idx;
                    res_slot     = 1'b1;
                    res_cmd.kind = CMD_CLEAR;
                    res_cmd.idx  = found_reg.match_idx;
                end
            end
            OP_LOGOUT_ALL:
                res_cmd.kind = CMD_CLEAR_ALL;
            OP_DROP_USER:
                res_cmd.kind = CMD_CLEAR_USER;
            default: ;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        role_next      = role_reg;
        key_next       = key_reg;
        launch_next    = 1'b0;
        found_next     = found_reg;
        auth_next      = auth_reg;
        lifetime_next  = lifetime_reg;
        out_valid_next = out_valid_reg;
        out_role_next  = out_role_reg;
        out_idx_next   = out_idx_reg;
        out_slot_next  = out_slot_reg;
        out_ev_next    = out_ev_reg;
        out_ex_next    = out_ex_reg;

        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_AUTH:     auth_next     = cfg.data[0];
                CFG_LIFETIME: lifetime_next = cfg.data[TIME_W-1:0];
                default: ;
            endcase
        end

        if (rsp.valid && rsp.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next        = req.operation;
                    role_next      = req.granted_role;
                    key_next.token = req.token;
                    key_next.now   = req.now_seconds;
                    key_next.admin = (req.granted_role == ROLE_ADMIN);
                    launch_next    = needs_scan;
                    state_next     = needs_scan ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                if (scan_done.valid)
                begin
                    found_next = scan_done;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (fire)
                begin
                    out_valid_next = 1'b1;
                    out_role_next  = res_role;
                    out_idx_next   = IDX_W'(res_idx);
                    out_slot_next  = res_slot;
                    out_ev_next    = res_ev;
                    out_ex_next    = res_ex;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            launch_reg    <= 1'b0;
            auth_reg      <= 1'b0;
            lifetime_reg  <= LIFETIME_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            launch_reg    <= launch_next;
            auth_reg      <= auth_next;
            lifetime_reg  <= lifetime_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        role_reg     <= role_next;
        key_reg      <= key_next;
        found_reg    <= found_next;
        out_role_reg <= out_role_next;
        out_idx_reg  <= out_idx_next;
        out_slot_reg <= out_slot_next;
        out_ev_reg   <= out_ev_next;
        out_ex_reg   <= out_ex_next;
    end

    always_comb
    begin
        scan_start       = '0;
        scan_start.valid = launch_reg;
    end

    assign key             = key_reg;
    assign cmd.kind        = fire ? res_cmd.kind : CMD_NONE;
    assign cmd.idx         = res_cmd.idx;
    assign rsp.valid       = out_valid_reg;
    assign rsp.result_role = out_role_reg;
    assign rsp.slot_index  = out_idx_reg;
    assign rsp.slot_valid  = out_slot_reg;
    assign rsp.evicted     = out_ev_reg;
    assign rsp.expired     = out_ex_reg;

endmodule

// ----- hw/rtl/session_slot_table_lru_unit.sv -----
// Top level of the session slot table: sequencer and the chain of slot cells.
//
// Channels: req takes one operation item (login, check role, logout, logout
// all, drop user sessions) with its role, token and time; rsp returns exactly
// one item per request; cfg writes auth_enabled (index 0) and
// session_lifetime (index 1) and is always ready.
// Lookup: an item that looks up the table walks a scan record through the
// SLOTS cells, one cell per cycle; the sequencer then registers the scan
// result and loads the answer into the output register. Items that need no
// lookup go straight to the finish step. The table update is applied in the
// cycle the result is loaded.
// Flow: one item at a time; req.ready is high only while the sequencer is
// idle, so a new item is accepted only once the last one has been loaded
// into the output register.
// Reset: all slots inactive, authentication off, lifetime 86400 seconds.
// Stall: the result sits in an output register; a new item is accepted
// while it waits, and that item's result holds in the sequencer until the
// output register is taken.
module session_slot_table_lru_unit import sst_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    sst_req_if.sink   req,
    sst_rsp_if.source rsp,
    sst_cfg_if.sink   cfg
);

    key_t  key;
    cmd_t  cmd;
    scan_t chain [SLOTS+1];

    sst_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .cfg        (cfg),
        .key        (key),
        .cmd        (cmd),
        .scan_start (chain[0]),
        .scan_done  (chain[SLOTS])
    );

    for (genvar k = 0; k < SLOTS; k++)
    begin : g_slot
        sst_cell u_slot
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (SLOT_W'(k)),
            .key      (key),
            .cmd      (cmd),
            .scan_in  (chain[k]),
            .scan_out (chain[k+1])
        );
    end

endmodule

// ----- tb/sv/tb_session_slot_table_lru_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the LRU session slot table: directed and random traffic vs a model.
module tb_session_slot_table_lru_unit import sst_pkg::*;
;

    localparam int LIMIT_NS      = 1_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_AT       = 300;
    localparam int HOLD_CYCLES   = 250;
    localparam int POOL_SIZE     = 10;
    localparam int REPORT_MAX    = 40;

    localparam logic [ROLE_W-1:0] ROLE_UNUSED = ROLE_W'(3);
    localparam logic [OP_W-1:0]   OP_UNUSED   = OP_DROP_USER + OP_W'(1);

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [ROLE_W-1:0]  granted_role;
        logic [TOKEN_W-1:0] token;
        logic [TIME_W-1:0]  now_seconds;
    } session_req_t;

    typedef struct packed {
        logic [ROLE_W-1:0] result_role;
        logic [IDX_W-1:0]  slot_index;
        logic              slot_valid;
        logic              evicted;
        logic              expired;
    } session_rsp_t;

    typedef enum logic [1:0] {STEP_ITEM, STEP_REG, STEP_DRAIN} step_kind_t;

    typedef struct {
        step_kind_t            kind;
        session_req_t          item;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
    } step_t;

    logic clk;
    logic rst_n;

    sst_req_if req_ch();
    sst_rsp_if rsp_ch();
    sst_cfg_if cfg_ch();

    session_slot_table_lru_unit DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    step_t        pending[$];
    session_rsp_t expected_answers[$];

    logic req_taken;
    logic rsp_taken;
    logic cfg_taken;
    int   mismatches;
    int   results_seen;
    int   send_gap;
    int   send_level;
    int   rsp_gap;
    int   recv_level;
    int   hold_left;
    bit   hold_done;

    bit                 auth_on;
    logic [TIME_W-1:0]  life_limit;
    bit                 sess_active [SLOTS];
    logic [TOKEN_W-1:0] sess_token  [SLOTS];
    bit                 sess_admin  [SLOTS];
    logic [TIME_W-1:0]  sess_created[SLOTS];
    logic [TIME_W-1:0]  sess_used   [SLOTS];

    logic [TOKEN_W-1:0] token_pool[POOL_SIZE];
    logic [TIME_W-1:0]  stim_clock;

    function automatic int pick_gap(int level);
        int r;
        if (level == 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 85 - 30 * level)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int slot_of_token(logic [TOKEN_W-1:0] tok);
        int hit;
        hit = -1;
        if (tok != '0)
            for (int i = SLOTS - 1; i >= 0; i--)
                if (sess_active[i] && sess_token[i] == tok)
                    hit = i;
        return hit;
    endfunction

    function automatic session_rsp_t apply_session_op(session_req_t r);
        session_rsp_t      a;
        int                hit;
        int                victim;
        logic [TIME_W-1:0] age;
        logic [TIME_W-1:0] oldest;
        bit                admin;
        a      = '0;
        hit    = -1;
        victim = -1;
        oldest = '0;
        case (r.operation)
            OP_LOGIN:
            begin
                if (!auth_on)
                    a.result_role = ROLE_ADMIN;
                else if ((r.granted_role == ROLE_USER || r.granted_role == ROLE_ADMIN)
                         && r.token != '0)
                begin
                    admin = (r.granted_role == ROLE_ADMIN);
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (hit < 0)
                        begin
                            if (!sess_active[i])
                                hit = i;
                            else if (admin || !sess_admin[i])
                            begin
                                age = r.now_seconds - sess_used[i];
                                if (victim < 0 || age > oldest)
                                begin
                                    victim = i;
                                    oldest = age;
                                end
                            end
                        end
                    end
                    if (hit < 0 && victim >= 0)
                    begin
                        hit       = victim;
                        a.evicted = 1'b1;
                    end
                    if (hit >= 0)
                    begin
                        sess_active[hit]  = 1'b1;
                        sess_token[hit]   = r.token;
                        sess_admin[hit]   = admin;
                        sess_created[hit] = r.now_seconds;
                        sess_used[hit]    = r.now_seconds;
                        a.result_role     = r.granted_role;
                    end
                end
            end
            OP_CHECK:
            begin
                if (!auth_on)
                    a.result_role = ROLE_ADMIN;
                else
                begin
                    hit = slot_of_token(r.token);
                    if (hit >= 0)
                    begin
                        age = r.now_seconds - sess_created[hit];
                        if (age > life_limit)
                        begin
                            sess_active[hit] = 1'b0;
                            a.expired        = 1'b1;
                        end
                        else
                        begin
                            sess_used[hit] = r.now_seconds;
                            a.result_role  = sess_admin[hit] ? ROLE_ADMIN : ROLE_USER;
                        end
                    end
                end
            end
            OP_LOGOUT:
            begin
                hit = slot_of_token(r.token);
                if (hit >= 0)
                    sess_active[hit] = 1'b0;
            end
            OP_LOGOUT_ALL:
            begin
                foreach (sess_active[i])
                    sess_active[i] = 1'b0;
            end
            OP_DROP_USER:
            begin
                foreach (sess_active[i])
                    if (!sess_admin[i])
                        sess_active[i] = 1'b0;
            end
            default: ;
        endcase
        if (hit >= 0)
        begin
            a.slot_valid = 1'b1;
            a.slot_index = IDX_W'(hit);
        end
        return a;
    endfunction

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
        end
    endtask

    task automatic add_item(input logic [OP_W-1:0] op, input logic [ROLE_W-1:0] role,
                            input logic [TOKEN_W-1:0] tok, input logic [TIME_W-1:0] now);
        step_t s;
        s.kind                   = STEP_ITEM;
        s.item.operation         = op;
        s.item.granted_role      = role;
        s.item.token             = tok;
        s.item.now_seconds       = now;
        s.reg_idx                = CFG_AUTH;
        s.reg_data               = '0;
        pending.push_back(s);
    endtask

    task automatic add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        step_t s;
        s.kind     = STEP_REG;
        s.item     = '0;
        s.reg_idx  = idx;
        s.reg_data = data;
        pending.push_back(s);
    endtask

    task automatic run_phase(input bit auth, input logic [TIME_W-1:0] life, input int count,
                             input logic [TIME_W-1:0] start);
        int                    r;
        logic [OP_W-1:0]       op;
        logic [ROLE_W-1:0]     role;
        logic [TOKEN_W-1:0]    tok;
        logic [CFG_DATA_W-1:0] d;
        step_t                 hold;
        d    = $urandom;
        d[0] = auth;
        add_reg(CFG_AUTH, d);
        add_reg(CFG_LIFETIME, life);
        stim_clock = start;
        foreach (token_pool[i])
            token_pool[i] = {$urandom, $urandom};
        token_pool[0] = {TOKEN_W{1'b1}};
        hold.kind     = STEP_DRAIN;
        hold.item     = '0;
        hold.reg_idx  = CFG_AUTH;
        hold.reg_data = '0;
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            if (r < 38)
                op = OP_LOGIN;
            else if (r < 76)
                op = OP_CHECK;
            else if (r < 88)
                op = OP_LOGOUT;
            else if (r < 90)
                op = OP_LOGOUT_ALL;
            else if (r < 96)
                op = OP_DROP_USER;
            else
                op = OP_UNUSED + OP_W'($urandom_range(0, 2));

            r = $urandom_range(0, 99);
            if (r < 45)
                role = ROLE_USER;
            else if (r < 90)
                role = ROLE_ADMIN;
            else if (r < 95)
                role = ROLE_NONE;
            else
                role = ROLE_UNUSED;

            r = $urandom_range(0, 99);
            if (r < 88)
                tok = token_pool[$urandom_range(0, POOL_SIZE - 1)];
            else if (r < 96)
                tok = {$urandom, $urandom};
            else
                tok = '0;

            r = $urandom_range(0, 99);
            if (r < 70)
                stim_clock += $urandom_range(0, 5);
            else if (r < 90)
                stim_clock += $urandom_range(6, 60);
            else if (r < 98)
                stim_clock += $urandom_range(61, 5000);
            else
                stim_clock = $urandom;

            add_item(op, role, tok, stim_clock);
            if ($urandom_range(0, 99) == 0)
                pending.push_back(hold);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #LIMIT_NS;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        logic [TIME_W-1:0] t0;
        rst_n = 1'b0;
        t0    = 32'hFFFF_FFFC;

        // auth off: everything is admin, logout still searches
        add_item(OP_LOGIN, ROLE_ADMIN, 64'h1, '0);
        add_item(OP_CHECK, ROLE_NONE, 64'h1, '0);
        add_item(OP_LOGOUT, ROLE_NONE, 64'h1, '0);

        add_reg(CFG_AUTH, 32'h1);
        add_reg(CFG_LIFETIME, 32'd100);
        add_item(OP_LOGIN, ROLE_NONE, 64'h5, t0);
        add_item(OP_LOGIN, ROLE_UNUSED, 64'h5, t0);
        add_item(OP_LOGIN, ROLE_USER, '0, t0);
        // fill every slot with admins across the time wrap
        for (int k = 0; k < SLOTS; k++)
            add_item(OP_LOGIN, ROLE_ADMIN,
                     (k == SLOTS - 1) ? {TOKEN_W{1'b1}} : TOKEN_W'(64'h100 + k), t0 + k);
        add_item(OP_LOGIN, ROLE_USER, 64'h200, t0 + 8);
        add_item(OP_LOGIN, ROLE_ADMIN, 64'h201, t0 + 9);
        add_item(OP_CHECK, ROLE_NONE, 64'h101, t0 + 10);
        add_item(OP_CHECK, ROLE_NONE, '0, t0 + 10);
        add_item(OP_CHECK, ROLE_NONE, 64'h102, t0 + 103);
        add_item(OP_CHECK, ROLE_NONE, 64'h103, t0 + 103);
        add_item(OP_LOGOUT, ROLE_NONE, {TOKEN_W{1'b1}}, t0 + 104);
        add_item(OP_LOGIN, ROLE_USER, 64'h300, t0 + 105);
        add_item(OP_DROP_USER, ROLE_NONE, '0, t0 + 106);
        add_item(OP_CHECK, ROLE_NONE, 64'h300, t0 + 107);
        add_item(OP_LOGOUT_ALL, ROLE_NONE, '0, t0 + 107);
        add_item(OP_LOGIN, ROLE_USER, 64'h400, t0 + 108);
        add_item(OP_LOGIN, ROLE_USER, 64'h400, t0 + 109);
        add_item(OP_CHECK, ROLE_NONE, 64'h400, t0 + 110);
        add_item(OP_UNUSED, ROLE_ADMIN, 64'h400, t0 + 111);

        run_phase(1'b1, 32'd50, 200, 32'h0000_1000);
        run_phase(1'b1, {TIME_W{1'b1}}, 150, 32'hFFFF_FF00);
        run_phase(1'b0, LIFETIME_RESET, 60, 32'h8000_0000);
        run_phase(1'b1, 32'd1, 120, 32'h7FFF_FFF0);
        run_phase(1'b1, $urandom_range(10, 1000), 390, $urandom);

        repeat (10) @(posedge clk);
        #0.5 rst_n = 1'b1;

        while (pending.size() != 0 || req_ch.valid || cfg_ch.valid)
            @(posedge clk);
        while (expected_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_answers.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    always @(negedge clk)
    begin : drive_items
        step_t s;
        logic  req_v;
        logic  cfg_v;
        if (rst_n)
        begin
            req_v = req_ch.valid && !req_taken;
            cfg_v = cfg_ch.valid && !cfg_taken;
            if (!req_v && !cfg_v)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending.size() != 0)
                begin
                    s = pending[0];
                    if (s.kind == STEP_ITEM)
                    begin
                        req_ch.operation    <= s.item.operation;
                        req_ch.granted_role <= s.item.granted_role;
                        req_ch.token        <= s.item.token;
                        req_ch.now_seconds  <= s.item.now_seconds;
                        req_v = 1'b1;
                        void'(pending.pop_front());
                        send_gap = pick_gap(send_level);
                        if ($urandom_range(0, 39) == 0)
                            send_level = $urandom_range(0, 2);
                    end
                    else if (expected_answers.size() == 0)
                    begin
                        if (s.kind == STEP_REG)
                        begin
                            cfg_ch.index <= s.reg_idx;
                            cfg_ch.data  <= s.reg_data;
                            cfg_v = 1'b1;
                        end
                        void'(pending.pop_front());
                    end
                end
            end
            req_ch.valid <= req_v;
            cfg_ch.valid <= cfg_v;
        end
        else
        begin
            req_ch.valid        <= 1'b0;
            req_ch.operation    <= OP_LOGIN;
            req_ch.granted_role <= ROLE_NONE;
            req_ch.token        <= '0;
            req_ch.now_seconds  <= '0;
            cfg_ch.valid        <= 1'b0;
            cfg_ch.index        <= CFG_AUTH;
            cfg_ch.data         <= '0;
            send_gap   = 0;
            send_level = 1;
        end
    end

    always @(negedge clk)
    begin : drive_ready
        if (rst_n)
        begin
            if (!hold_done && results_seen >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (rsp_taken)
            begin
                rsp_gap = pick_gap(recv_level);
                if ($urandom_range(0, 39) == 0)
                    recv_level = $urandom_range(0, 2);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (rsp_gap > 0)
            begin
                rsp_gap--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
        else
        begin
            rsp_ch.ready <= 1'b0;
            recv_level = 1;
        end
    end

    always @(posedge clk)
    begin : watch_channels
        session_rsp_t got;
        session_rsp_t want;
        session_req_t seen;
        req_taken <= rst_n && req_ch.valid && req_ch.ready;
        rsp_taken <= rst_n && rsp_ch.valid && rsp_ch.ready;
        cfg_taken <= rst_n && cfg_ch.valid && cfg_ch.ready;
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                if (cfg_ch.index == CFG_AUTH)
                    auth_on = cfg_ch.data[0];
                else if (cfg_ch.index == CFG_LIFETIME)
                    life_limit = cfg_ch.data;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                results_seen++;
                got.result_role = rsp_ch.result_role;
                got.slot_index  = rsp_ch.slot_index;
                got.slot_valid  = rsp_ch.slot_valid;
                got.evicted     = rsp_ch.evicted;
                got.expired     = rsp_ch.expired;
                if (expected_answers.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: expected no result, got role %0d slot %0d/%0b ev %0b ex %0b",
                                 $time, got.result_role, got.slot_index, got.slot_valid,
                                 got.evicted, got.expired);
                end
                else
                begin
                    want = expected_answers.pop_front();
                    check_field("result_role", 64'(want.result_role), 64'(got.result_role));
                    check_field("slot_index", 64'(want.slot_index), 64'(got.slot_index));
                    check_field("slot_valid", 64'(want.slot_valid), 64'(got.slot_valid));
                    check_field("evicted", 64'(want.evicted), 64'(got.evicted));
                    check_field("expired", 64'(want.expired), 64'(got.expired));
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                seen.operation    = req_ch.operation;
                seen.granted_role = req_ch.granted_role;
                seen.token        = req_ch.token;
                seen.now_seconds  = req_ch.now_seconds;
                expected_answers.push_back(apply_session_op(seen));
            end
        end
        else
        begin
            auth_on    = 1'b0;
            life_limit = LIFETIME_RESET;
        end
    end

endmodule

// ----- sim.f -----
hw/rtl/sst_pkg.sv
hw/rtl/sst_if.sv
hw/rtl/sst_cell.sv
hw/rtl/sst_ctrl.sv
hw/rtl/session_slot_table_lru_unit.sv
tb/sv/tb_session_slot_table_lru_unit.sv
